// ===== hdl/bbc_pkg.sv =====
package bbc_pkg;

   localparam int STACK_DEPTH = 1024;

   localparam int CODE_W = 2;

   // opener / closer codes
   localparam logic [CODE_W-1:0] CODE_BRACE  = 2'd0;
   localparam logic [CODE_W-1:0] CODE_SQUARE = 2'd1;
   localparam logic [CODE_W-1:0] CODE_PAREN  = 2'd2;
   localparam logic [CODE_W-1:0] CODE_NONE   = 2'd3;

   localparam logic [7:0] CHAR_LBRACE  = 8'h7B; // {
   localparam logic [7:0] CHAR_LSQUARE = 8'h5B; // [
   localparam logic [7:0] CHAR_LPAREN  = 8'h28; // (
   localparam logic [7:0] CHAR_RBRACE  = 8'h7D; // }
   localparam logic [7:0] CHAR_RSQUARE = 8'h5D; // ]
   localparam logic [7:0] CHAR_RPAREN  = 8'h29; // )

   // shift command for the cell row
   typedef struct packed {
      logic push;
      logic pop;
   } stack_ctrl_type;

   function automatic logic [CODE_W-1:0] opener_code(input logic [7:0] ch);
      logic [CODE_W-1:0] code;
      code = CODE_NONE;
      if (ch == CHAR_LBRACE)       code = CODE_BRACE;
      else if (ch == CHAR_LSQUARE) code = CODE_SQUARE;
      else if (ch == CHAR_LPAREN)  code = CODE_PAREN;
      return code;
   endfunction

   function automatic logic [CODE_W-1:0] closer_code(input logic [7:0] ch);
      logic [CODE_W-1:0] code;
      code = CODE_NONE;
      if (ch == CHAR_RBRACE)       code = CODE_BRACE;
      else if (ch == CHAR_RSQUARE) code = CODE_SQUARE;
      else if (ch == CHAR_RPAREN)  code = CODE_PAREN;
      return code;
   endfunction

endpackage

// ===== hdl/bracket_balance_checker_top.sv =====
// The verdict of a line_end transaction is registered in the output register, or in the skid entry while that waits.
// Throughput: 1 character per cycle while req_stall is low; every push or pop shifts the whole cell row at once.
// A two-entry output (register plus skid) lets input flow on while one verdict waits.
// Reset (synchronous, active high) clears the depth count, the failure flag and the
// output valids; stack cells are not cleared and no clearing pass is needed.
module bracket_balance_checker_top #(
   parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_symbol,
   input  logic       req_line_end,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_well_formed
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   // ------------------------------------------------------------------
   // Stack: a row of cells, cell 0 is the top. Occupancy lives in a
   // separate counter; cells at or below the count hold stale data.
   // ------------------------------------------------------------------
   logic [CNT_W-1:0]           depth_ff, depth_in;
   logic                       failed_ff, failed_in;
   bbc_pkg::stack_ctrl_type    ctrl;
   logic [bbc_pkg::CODE_W-1:0] cell_code [STACK_DEPTH];
   logic [bbc_pkg::CODE_W-1:0] push_code;

   // output register and skid entry
   logic rsp_valid_ff,  rsp_valid_in;
   logic rsp_wf_ff,     rsp_wf_in;
   logic skid_valid_ff, skid_valid_in;
   logic skid_wf_ff,    skid_wf_in;

   logic req_fire, rsp_fire;
   logic verdict_valid, verdict;
   logic is_opener, stack_full, stack_empty;

   assign req_stall = skid_valid_ff;
   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = rsp_valid_ff && !rsp_stall;

   assign push_code   = bbc_pkg::opener_code(req_symbol);
   assign is_opener   = (push_code != bbc_pkg::CODE_NONE);
   assign stack_full  = (depth_ff == CNT_W'(STACK_DEPTH));
   assign stack_empty = (depth_ff == '0);

   // Character handling. After a failure the rest of the line is dropped.
   always_comb begin
      depth_in      = depth_ff;
      failed_in     = failed_ff;
      ctrl          = '0;
      verdict_valid = 1'b0;
      verdict       = !failed_ff && stack_empty;
      if (req_fire) begin
         if (req_line_end) begin
            verdict_valid = 1'b1;
            depth_in      = '0;
            failed_in     = 1'b0;
         end else if (!failed_ff) begin
            if (is_opener) begin
               if (stack_full) begin
                  failed_in = 1'b1;   // overflow counts as a failure
               end else begin
                  ctrl.push = 1'b1;
                  depth_in  = depth_ff + 1'b1;
               end
            end else if (stack_empty) begin
               failed_in = 1'b1;      // closer with nothing open
            end else begin
               ctrl.pop = 1'b1;
               depth_in = depth_ff - 1'b1;
               if (bbc_pkg::closer_code(req_symbol) != cell_code[0]) begin
                  failed_in = 1'b1;
               end
            end
         end
      end
   end

   genvar i;
   generate
      for (i = 0; i < STACK_DEPTH; i++) begin : g_cell
         logic [bbc_pkg::CODE_W-1:0] up_code, down_code;
         if (i == 0) begin : g_first
            assign up_code = push_code;
         end else begin : g_mid_up
            assign up_code = cell_code[i-1];
         end
         if (i == STACK_DEPTH - 1) begin : g_last
            assign down_code = cell_code[i];
         end else begin : g_mid_down
            assign down_code = cell_code[i+1];
         end
         bbc_cell u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .from_up   (up_code),
            .from_down (down_code),
            .code      (cell_code[i])
         );
      end
   endgenerate

   // ------------------------------------------------------------------
   // Response side: the skid entry catches a verdict that arrives while
   // the output register is stalled; input stalls only while it is full.
   // ------------------------------------------------------------------
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_wf_in     = rsp_wf_ff;
      skid_valid_in = skid_valid_ff;
      skid_wf_in    = skid_wf_ff;
      if (skid_valid_ff) begin
         if (rsp_fire) begin
            rsp_valid_in  = 1'b1;
            rsp_wf_in     = skid_wf_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!rsp_valid_ff || rsp_fire) begin
         rsp_valid_in = verdict_valid;
         rsp_wf_in    = verdict;
      end else if (verdict_valid) begin
         skid_valid_in = 1'b1;
         skid_wf_in    = verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff      <= '0;
         failed_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         depth_ff      <= depth_in;
         failed_ff     <= failed_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_wf_ff  <= rsp_wf_in;
      skid_wf_ff <= skid_wf_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_well_formed = rsp_wf_ff;

endmodule

// ===== hdl/bbc_cell.sv =====
// One stack slot. Push takes the neighbor above, pop the neighbor below.
module bbc_cell (
   input  logic                        clock,
   input  bbc_pkg::stack_ctrl_type     ctrl,
   input  logic [bbc_pkg::CODE_W-1:0]  from_up,
   input  logic [bbc_pkg::CODE_W-1:0]  from_down,
   output logic [bbc_pkg::CODE_W-1:0]  code
);

   logic [bbc_pkg::CODE_W-1:0] code_ff;
   logic [bbc_pkg::CODE_W-1:0] code_in;

   always_comb begin
      code_in = code_ff;
      if (ctrl.push) begin
         code_in = from_up;
      end else if (ctrl.pop) begin
         code_in = from_down;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

   assign code = code_ff;

endmodule

// ===== tb/bbc_verdict_checker.sv =====
// Watches both channels of the bracket balance checker, tracks the bracket
// stack of the current line and compares every well_formed verdict.
module bbc_verdict_checker
   import bbc_pkg::*;
#(
   parameter int DEPTH = STACK_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_symbol,
   input  logic       req_line_end,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_well_formed,
   output int         mismatches,
   output int         verdicts_pending
);

   logic [CODE_W-1:0] open_codes [DEPTH];
   int unsigned       open_count;
   bit                line_broken;
   bit                verdict_queue[$];
   bit                expected_verdict;
   int                fail_total = 0;

   assign mismatches = fail_total;

   task automatic report_mismatch(input string what);
      $display("%0t: mismatch: %s", $realtime, what);
      fail_total++;
   endtask

   // one character or end of line through the stack
   task automatic track_symbol(input logic [7:0] sym, input logic line_end);
      logic [CODE_W-1:0] wanted;
      if (line_end) begin
         verdict_queue.push_back(!line_broken && open_count == 0);
         open_count  = 0;
         line_broken = 1'b0;
      end else if (!line_broken) begin
         case (sym)
            CHAR_LBRACE, CHAR_LSQUARE, CHAR_LPAREN: begin
               if (open_count >= DEPTH) begin
                  line_broken = 1'b1;    // full stack: no push, line fails
               end else begin
                  open_codes[open_count] = (sym == CHAR_LBRACE)  ? CODE_BRACE  :
                                           (sym == CHAR_LSQUARE) ? CODE_SQUARE : CODE_PAREN;
                  open_count++;
               end
            end
            default: begin
               wanted = (sym == CHAR_RBRACE)  ? CODE_BRACE  :
                        (sym == CHAR_RSQUARE) ? CODE_SQUARE :
                        (sym == CHAR_RPAREN)  ? CODE_PAREN  : CODE_NONE;
               if (open_count == 0) begin
                  line_broken = 1'b1;
               end else begin
                  open_count--;
                  if (open_codes[open_count] != wanted) line_broken = 1'b1;
               end
            end
         endcase
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         open_count  = 0;
         line_broken = 1'b0;
         verdict_queue.delete();
         verdicts_pending <= 0;
      end else begin
         // a verdict leaving now belongs to an earlier line end
         if (rsp_valid && !rsp_stall) begin
            if (verdict_queue.size() == 0) begin
               report_mismatch($sformatf("unexpected verdict %b", rsp_well_formed));
            end else begin
               expected_verdict = verdict_queue.pop_front();
               if (rsp_well_formed !== expected_verdict)
                  report_mismatch($sformatf("well_formed %b, expected %b",
                                            rsp_well_formed, expected_verdict));
            end
         end
         if (req_valid && !req_stall) track_symbol(req_symbol, req_line_end);
         verdicts_pending <= verdict_queue.size();
      end
   end

endmodule

// ===== tb/bracket_balance_checker_top_test.sv =====
// Stimulus and verdict for the bracket balance checker. A directed set of
// short lines comes first, then one line that overflows the stack, then
// random lines: mostly nested bracket strings, some of them corrupted,
// plus noise and empty lines. The verdict checker beside the block does all
// prediction and comparison.
module bracket_balance_checker_top_test;

   localparam int IDLE_LIMIT   = 1000;   // cycles with no transaction at all
   localparam int TOTAL_ITEMS  = 1800;   // all transactions, directed ones included
   localparam int DRAIN_CYCLES = 8;      // settling time after every verdict is back
   localparam int CODE_W       = bbc_pkg::CODE_W;

   logic       clock        = 1'b0;
   logic       reset        = 1'b1;
   logic       req_valid    = 1'b0;
   logic       req_stall;
   logic [7:0] req_symbol   = 8'h00;
   logic       req_line_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall    = 1'b0;
   logic       rsp_well_formed;

   int mismatch_count;
   int verdicts_pending;
   int idle_cycles = 0;
   int items_sent  = 0;
   int rsp_hold    = 0;
   int stall_len;
   bit quiet_phase = 1'b0;               // no idling on either side while set

   logic [7:0]        line_chars[$];     // characters of the line being built
   logic [CODE_W-1:0] open_kinds[$];     // openers still to close while building

   always #5 clock = ~clock;

   bracket_balance_checker_top #(
      .STACK_DEPTH(bbc_pkg::STACK_DEPTH)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_symbol     (req_symbol),
      .req_line_end   (req_line_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_well_formed(rsp_well_formed)
   );

   bbc_verdict_checker #(
      .DEPTH(bbc_pkg::STACK_DEPTH)
   ) i_verdict_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_symbol      (req_symbol),
      .req_line_end    (req_line_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_well_formed (rsp_well_formed),
      .mismatches      (mismatch_count),
      .verdicts_pending(verdicts_pending)
   );

   // Gap length shared by sender and receiver: mostly none, some short,
   // a few long.
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet_phase || roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] opener_char(input logic [CODE_W-1:0] kind);
      case (kind)
         bbc_pkg::CODE_BRACE:  return bbc_pkg::CHAR_LBRACE;
         bbc_pkg::CODE_SQUARE: return bbc_pkg::CHAR_LSQUARE;
         default:              return bbc_pkg::CHAR_LPAREN;
      endcase
   endfunction

   function automatic logic [7:0] closer_char(input logic [CODE_W-1:0] kind);
      case (kind)
         bbc_pkg::CODE_BRACE:  return bbc_pkg::CHAR_RBRACE;
         bbc_pkg::CODE_SQUARE: return bbc_pkg::CHAR_RSQUARE;
         default:              return bbc_pkg::CHAR_RPAREN;
      endcase
   endfunction

   function automatic logic [CODE_W-1:0] random_kind();
      return CODE_W'($urandom_range(bbc_pkg::CODE_BRACE, bbc_pkg::CODE_PAREN));
   endfunction

   // One transaction. Valid stays high from one transaction to the next when
   // there is no gap, so it never gets two assignments in one step.
   task automatic send_item(input logic [7:0] sym, input logic line_end);
      int gap;
      gap = idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_symbol   <= sym;
      req_line_end <= line_end;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Characters of line_chars, then the line end with a random symbol,
   // which the block must ignore.
   task automatic send_line();
      foreach (line_chars[i]) send_item(line_chars[i], 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic queue_text(input string text);
      line_chars.delete();
      for (int i = 0; i < text.len(); i++) line_chars.push_back(text[i]);
   endtask

   // Sender holds off until every verdict is back.
   task automatic wait_for_verdicts();
      req_valid <= 1'b0;
      do @(posedge clock); while (verdicts_pending != 0);
   endtask

   // Properly nested string with the given number of bracket pairs.
   task automatic build_balanced(input int pairs);
      int opened;
      logic [CODE_W-1:0] kind;
      opened = 0;
      open_kinds.delete();
      while (opened < pairs || open_kinds.size() != 0) begin
         if (opened < pairs && (open_kinds.size() == 0 || $urandom_range(0, 1) == 1)) begin
            kind = random_kind();
            open_kinds.push_back(kind);
            line_chars.push_back(opener_char(kind));
            opened++;
         end else begin
            line_chars.push_back(closer_char(open_kinds.pop_back()));
         end
      end
   endtask

   // Break a nested line in one of several ways.
   task automatic corrupt_line();
      int spot;
      spot = (line_chars.size() > 0) ? $urandom_range(0, line_chars.size() - 1) : 0;
      case ($urandom_range(0, 3))
         0: if (line_chars.size() > 0) line_chars[spot] = 8'($urandom_range(0, 255));
         1: line_chars.push_back(closer_char(random_kind()));    // extra closer
         2: if (line_chars.size() > 0) line_chars.delete(spot);  // lost character
         default: line_chars.insert(spot, opener_char(random_kind()));
      endcase
   endtask

   // Receiver: stall stretches of random length, each followed by a free
   // stretch before the next one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
         rsp_hold  <= $urandom_range(0, 4);
      end else begin
         stall_len = idle_length();
         if (stall_len > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold  <= stall_len - 1;
         end
      end
   end

   // Watchdog: too long without any transaction on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("bracket_balance_checker_top verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int roll;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed lines
      send_item(8'hFF, 1'b1);             // empty line is well formed
      queue_text("{}");  send_line();
      queue_text("[]");  send_line();
      queue_text("()");  send_line();
      queue_text("(]");  send_line();     // wrong closer
      queue_text("}");   send_line();     // closer on empty stack
      queue_text("a");   send_line();     // plain letter counts as closer
      line_chars = '{8'h00}; send_line(); // NUL
      line_chars = '{8'hFF}; send_line();
      queue_text("{");   send_line();     // left open
      queue_text("[a]"); send_line();     // rest ignored after failure
      wait_for_verdicts();

      // fill the stack exactly, then one opener too many
      line_chars.delete();
      repeat (bbc_pkg::STACK_DEPTH + 1) line_chars.push_back(opener_char(random_kind()));
      line_chars.push_back(bbc_pkg::CHAR_RPAREN);
      send_line();
      wait_for_verdicts();

      // random lines until the overall transaction count is reached
      while (items_sent < TOTAL_ITEMS) begin
         if ($urandom_range(0, 9) == 0) quiet_phase = !quiet_phase;
         line_chars.delete();
         roll = $urandom_range(0, 99);
         if (roll < 65) begin
            build_balanced($urandom_range(0, 12));
            if ($urandom_range(0, 3) == 0) corrupt_line();
         end else if (roll < 85) begin
            // noise: brackets of all six kinds mixed with arbitrary bytes
            repeat ($urandom_range(1, 10)) begin
               case ($urandom_range(0, 3))
                  0:       line_chars.push_back(opener_char(random_kind()));
                  1:       line_chars.push_back(closer_char(random_kind()));
                  default: line_chars.push_back(8'($urandom_range(0, 255)));
               endcase
            end
         end else if (roll < 95) begin
            build_balanced($urandom_range(13, 60));
         end
         // the rest stay empty
         send_line();
         if ($urandom_range(0, 39) == 0) wait_for_verdicts();
      end

      wait_for_verdicts();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("bracket_balance_checker_top verification clean");
      else
         $display("bracket_balance_checker_top verification failed");
      $finish;
   end

endmodule
